// ===== sv/psh_pkg.sv =====
// shared types and constants for the positional string hash
package psh_pkg;

    localparam int unsigned HASH_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [HASH_W-1:0] HASH_FACTOR = 32'd6293815;
    localparam logic [HASH_W-1:0] POS_START   = 32'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BLANKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLD_UPPER  = 8'd1;

    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

    // classified character as it travels from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] char_byte;
        logic              keep;
        logic              last;
    } t_item;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_queue_status;

endpackage

// ===== sv/psh_front.sv =====
// front end: accepts characters, marks blanks for dropping and folds case
module psh_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_char_byte,
    input  logic                 i_end_of_string,
    input  psh_pkg::t_queue_status i_qstat,
    output logic                 o_push,
    output psh_pkg::t_item       o_item
);
    import psh_pkg::*;

    logic r_skip_blanks;
    logic r_fold_upper;
    logic is_blank;
    logic is_lower;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_blanks <= 1'b0;
            r_fold_upper  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SKIP_BLANKS: r_skip_blanks <= i_cfg_data;
                CFG_FOLD_UPPER:  r_fold_upper  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        is_blank = (i_char_byte == 8'h20) || (i_char_byte inside {[8'h09:8'h0D]});
        is_lower = i_char_byte inside {[8'h61:8'h7A]};
    end

    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_item.keep      = !(r_skip_blanks && is_blank);
        o_item.last      = i_end_of_string;
        o_item.char_byte = (r_fold_upper && is_lower) ? (i_char_byte - CASE_OFFSET)
                                                      : i_char_byte;
    end

endmodule

// ===== sv/psh_queue.sv =====
// two-entry queue between front end and hash engine
module psh_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  psh_pkg::t_item         i_item,
    input  logic                   i_pop,
    output psh_pkg::t_item         o_head,
    output psh_pkg::t_queue_status o_qstat
);
    import psh_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head            = r_mem[r_rd_ptr];
    assign o_qstat.not_empty = (r_count != 2'd0);
    assign o_qstat.full      = (r_count == 2'd2);

endmodule

// ===== sv/psh_back.sv =====
// hash engine: two-step multiply-accumulate and result register
module psh_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  psh_pkg::t_item         i_head,
    input  psh_pkg::t_queue_status i_qstat,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [31:0]            o_hash_value
);
    import psh_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_MUL  = 2'b10
    } t_state;

    t_state            r_state;
    logic [HASH_W-1:0] r_sum;
    logic [HASH_W-1:0] r_mult;
    logic [HASH_W-1:0] r_pos;
    logic [HASH_W-1:0] r_prod;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out;

    logic              out_free;
    logic              emit_drop;
    logic              emit_mul;
    logic [HASH_W-1:0] sum_new;

    assign out_free = !r_out_valid || i_ready;
    assign sum_new  = r_sum + r_prod * {{(HASH_W-BYTE_W){1'b0}}, r_byte};

    always_comb begin
        o_pop     = 1'b0;
        emit_drop = 1'b0;
        emit_mul  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_qstat.not_empty) begin
                    // a dropped final blank still ends the string
                    if (!i_head.keep && i_head.last) begin
                        o_pop     = out_free;
                        emit_drop = out_free;
                    end else begin
                        o_pop = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                emit_mul = r_last && out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_mult      <= HASH_FACTOR;
            r_pos       <= POS_START;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_drop || emit_mul) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (emit_drop) begin
                        r_sum  <= '0;
                        r_mult <= HASH_FACTOR;
                        r_pos  <= POS_START;
                    end else if (o_pop && i_head.keep) begin
                        r_mult  <= r_mult * HASH_FACTOR;
                        r_pos   <= r_pos + 32'd1;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (!r_last) begin
                        r_sum   <= sum_new;
                        r_state <= ST_IDLE;
                    end else if (emit_mul) begin
                        r_sum   <= '0;
                        r_mult  <= HASH_FACTOR;
                        r_pos   <= POS_START;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && o_pop) begin
            r_prod <= r_mult * r_pos;
            r_byte <= i_head.char_byte;
            r_last <= i_head.last;
        end
        if (emit_drop) begin
            r_out <= r_sum;
        end else if (emit_mul) begin
            r_out <= sum_new;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out;

endmodule

// ===== sv/positional_string_hash.sv =====
// Positional string hash, top level. Characters arrive one per transaction
// on the input channel and are classified by the front end (blank dropping
// and upper-case folding, both set through the configuration channel, index
// 0 and 1) into a two-entry queue. For each counted character the hash engine
// first registers the product multiplier*index and then multiplies it by the
// byte and adds it to the sum, and only then takes the next character from
// the queue; a dropped blank is popped without a multiply. The input accepts
// one character per cycle while the queue has room. A string's hash is
// registered on the output channel when its final character is processed and
// waits in an output register while the next string is already being hashed.
module positional_string_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_byte,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash_value
);
    import psh_pkg::*;

    t_item         push_item;
    t_item         head_item;
    t_queue_status qstat;
    logic          push;
    logic          pop;

    psh_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_byte     (i_char_byte),
        .i_end_of_string (i_end_of_string),
        .i_qstat         (qstat),
        .o_push          (push),
        .o_item          (push_item)
    );

    psh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_qstat (qstat)
    );

    psh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_item),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

endmodule
